>>> src/usm_pkg.sv
// Shared types, character constants and byte classifiers for the URL span marker.
`default_nettype none

package usm_pkg;

   // Scheme letter limit: default and the largest value the design is sized for.
   localparam int SCHEME_MAX_DEF = 32;
   localparam int SCHEME_MAX_TOP = 60;

   // Count width that covers the queue depth at the largest scheme limit.
   localparam int CNT_W = $clog2(SCHEME_MAX_TOP + 6);

   // Saturation value of the trailing 'w' counter.
   localparam logic [1:0] W_RUN_FULL = 2'd3;

   // Characters that take part in link detection.
   localparam logic [7:0] CH_COLON      = 8'h3A;
   localparam logic [7:0] CH_SLASH      = 8'h2F;
   localparam logic [7:0] CH_PERCENT    = 8'h25;
   localparam logic [7:0] CH_DOT        = 8'h2E;
   localparam logic [7:0] CH_DASH       = 8'h2D;
   localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
   localparam logic [7:0] CH_QUESTION   = 8'h3F;
   localparam logic [7:0] CH_EQUALS     = 8'h3D;
   localparam logic [7:0] CH_W_LOWER    = 8'h77;
   localparam logic [7:0] CH_W_UPPER    = 8'h57;
   localparam logic [7:0] CH_LOWER_A    = 8'h61;
   localparam logic [7:0] CH_LOWER_Z    = 8'h7A;
   localparam logic [7:0] CH_UPPER_A    = 8'h41;
   localparam logic [7:0] CH_UPPER_Z    = 8'h5A;
   localparam logic [7:0] CH_DIGIT_0    = 8'h30;
   localparam logic [7:0] CH_DIGIT_9    = 8'h39;

   // Kind of link the scanner is currently inside.
   typedef enum logic [1:0] {
      LINK_NONE,
      LINK_SCHEME,
      LINK_WWW
   } link_mode_type;

   // Progress through the "://" separator.
   typedef enum logic [1:0] {
      PFX_NONE,
      PFX_COLON,
      PFX_SLASH
   } prefix_type;

   // What one accepted item does to the byte queue.
   typedef struct packed {
      logic [CNT_W-1:0] rel_cnt;    // held bytes released from the front
      logic [CNT_W-1:0] plain_cnt;  // leading released bytes that are plain
      logic             emit;       // the new byte is released at once
      logic             link;       // the new byte lies inside a link
   } decision_type;

   function automatic logic is_alpha(input logic [7:0] b);
      return ((b >= CH_LOWER_A) && (b <= CH_LOWER_Z)) ||
             ((b >= CH_UPPER_A) && (b <= CH_UPPER_Z));
   endfunction

   function automatic logic is_alnum(input logic [7:0] b);
      return is_alpha(b) || ((b >= CH_DIGIT_0) && (b <= CH_DIGIT_9));
   endfunction

   function automatic logic is_w(input logic [7:0] b);
      return (b == CH_W_LOWER) || (b == CH_W_UPPER);
   endfunction

   // Characters allowed inside a link; scheme links accept a few more.
   function automatic logic in_link_set(input logic [7:0] b, input logic scheme);
      logic base_set;
      logic scheme_set;
      base_set   = is_alnum(b) || (b == CH_SLASH) || (b == CH_PERCENT) || (b == CH_DOT);
      scheme_set = (b == CH_DASH) || (b == CH_UNDERSCORE) ||
                   (b == CH_QUESTION) || (b == CH_EQUALS);
      return base_set || (scheme && scheme_set);
   endfunction

endpackage

`default_nettype wire

>>> src/usm_if.sv
// Valid/ready channel interfaces for text items in and marked items out.
`default_nettype none

interface usm_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       in_last;

   modport source (output valid, output in_byte, output in_last, input ready);
   modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

interface usm_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       out_link;
   logic       out_last;

   modport source (output valid, output out_byte, output out_link, output out_last,
                   input ready);
   modport sink (input valid, input out_byte, input out_link, input out_last,
                 output ready);
endinterface

`default_nettype wire

>>> src/usm_scan.sv
// Link scanner: tracks link, separator and letter state and decides each item's release.
`default_nettype none

module usm_scan #(
   parameter int SCHEME_MAX = usm_pkg::SCHEME_MAX_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        take,
   input  logic [7:0]                  scan_byte,
   input  logic                        scan_last,
   input  logic [usm_pkg::CNT_W-1:0]   hold_cnt,
   output usm_pkg::decision_type       decision
);
   import usm_pkg::*;

   localparam int LETTER_HOLD = (SCHEME_MAX > 3) ? SCHEME_MAX : 3;
   localparam int LR_W        = $clog2(LETTER_HOLD + 1);

   link_mode_type    link_mode_ff, link_mode_in;
   prefix_type       prefix_ff, prefix_in;
   logic [LR_W-1:0]  letter_run_ff, letter_run_in;
   logic [1:0]       w_run_ff, w_run_in;

   logic            b_colon, b_slash, b_dot, b_alpha, b_w;
   logic            in_link, in_set;
   logic            path_link, path_slash, path_scheme;
   logic            judge_clear, judge_www, judge_over;
   logic [LR_W-1:0] eff_letters, keep;
   logic [1:0]      eff_w, w_next;

   // Byte classes and the path the item takes.
   always_comb begin
      b_colon     = (scan_byte == CH_COLON);
      b_slash     = (scan_byte == CH_SLASH);
      b_dot       = (scan_byte == CH_DOT);
      b_alpha     = is_alpha(scan_byte);
      b_w         = is_w(scan_byte);
      in_link     = (link_mode_ff != LINK_NONE);
      in_set      = in_link_set(scan_byte, link_mode_ff == LINK_SCHEME);
      path_link   = in_link && in_set;
      path_slash  = !in_link && (prefix_ff == PFX_COLON) && b_slash;
      path_scheme = !in_link && (prefix_ff == PFX_SLASH) && b_slash;
      // A link exit or a broken separator judges the byte with no letters before it.
      judge_clear = in_link || (prefix_ff != PFX_NONE);
      eff_letters = judge_clear ? '0 : letter_run_ff;
      eff_w       = judge_clear ? '0 : w_run_ff;
      judge_www   = b_dot && (eff_letters >= LR_W'(3)) && (eff_w == W_RUN_FULL);
      judge_over  = (eff_letters == LR_W'(LETTER_HOLD));
      keep        = (letter_run_ff < LR_W'(SCHEME_MAX)) ? letter_run_ff : LR_W'(SCHEME_MAX);
      w_next      = b_w ? ((eff_w == W_RUN_FULL) ? W_RUN_FULL : eff_w + 2'd1) : 2'd0;
   end

   // Next state.
   always_comb begin
      link_mode_in  = link_mode_ff;
      prefix_in     = prefix_ff;
      letter_run_in = letter_run_ff;
      w_run_in      = w_run_ff;
      if (scan_last) begin
         link_mode_in  = LINK_NONE;
         prefix_in     = PFX_NONE;
         letter_run_in = '0;
         w_run_in      = '0;
      end else if (path_link) begin
         link_mode_in = link_mode_ff;
      end else if (path_slash) begin
         prefix_in = PFX_SLASH;
      end else if (path_scheme) begin
         link_mode_in  = LINK_SCHEME;
         prefix_in     = PFX_NONE;
         letter_run_in = '0;
         w_run_in      = '0;
      end else begin
         link_mode_in  = LINK_NONE;
         prefix_in     = PFX_NONE;
         letter_run_in = '0;
         w_run_in      = '0;
         if (b_colon) begin
            prefix_in     = PFX_COLON;
            letter_run_in = eff_letters;
            w_run_in      = eff_w;
         end else if (judge_www) begin
            link_mode_in = LINK_WWW;
         end else if (b_alpha) begin
            letter_run_in = judge_over ? eff_letters : eff_letters + LR_W'(1);
            w_run_in      = w_next;
         end
      end
   end

   // Release decision for the queue.
   always_comb begin
      decision = '0;
      if (path_link) begin
         decision.emit = 1'b1;
         decision.link = 1'b1;
      end else if (path_slash) begin
         decision.emit = 1'b0;
      end else if (path_scheme) begin
         decision.rel_cnt   = hold_cnt;
         decision.plain_cnt = CNT_W'(letter_run_ff - keep);
         decision.emit      = 1'b1;
         decision.link      = 1'b1;
      end else if (b_colon) begin
         decision.rel_cnt   = judge_clear ? hold_cnt : '0;
         decision.plain_cnt = decision.rel_cnt;
      end else if (judge_www) begin
         decision.rel_cnt   = hold_cnt;
         decision.plain_cnt = hold_cnt - CNT_W'(3);
         decision.emit      = 1'b1;
         decision.link      = 1'b1;
      end else if (b_alpha) begin
         if (judge_clear) begin
            decision.rel_cnt = hold_cnt;
         end else begin
            decision.rel_cnt = judge_over ? CNT_W'(1) : '0;
         end
         decision.plain_cnt = decision.rel_cnt;
      end else begin
         decision.rel_cnt   = hold_cnt;
         decision.plain_cnt = hold_cnt;
         decision.emit      = 1'b1;
      end
      // The final byte of the text flushes everything still held as plain text.
      if (scan_last && !decision.emit) begin
         decision.rel_cnt   = hold_cnt;
         decision.plain_cnt = hold_cnt;
         decision.emit      = 1'b1;
         decision.link      = 1'b0;
      end
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         link_mode_ff  <= LINK_NONE;
         prefix_ff     <= PFX_NONE;
         letter_run_ff <= '0;
         w_run_ff      <= '0;
      end else if (take) begin
         link_mode_ff  <= link_mode_in;
         prefix_ff     <= prefix_in;
         letter_run_ff <= letter_run_in;
         w_run_ff      <= w_run_in;
      end
   end

endmodule

`default_nettype wire

>>> src/url_span_marker_top.sv
// Top level of the URL span marker: input handshake, byte queue and output stage.
//
// Text enters one byte per item on req_chan (in_byte, in_last). Every byte leaves
// on rsp_chan in its original order with out_link set when it lies inside a
// scheme link ("letters://...") or a www link ("www...."), and out_last set on
// the final byte of a text. Both channels move an item when valid and ready are
// high at a rising clock edge.
// A byte decided at once is queued as decided. Bytes that could still start a
// link (letters, ':' and ":/") stay in the queue until a later byte decides
// them, up to SCHEME_MAX + 2 bytes for a scheme; the final byte of a text
// releases all of them. Throughput is one item per cycle on each side while the
// queue is not full and its head is decided. The queue holds SCHEME_MAX + 5
// bytes (at least 8); req_chan.ready drops only while it is full, which happens
// only when the receiver stalls. The output is taken straight from the queue
// head register, so a stall on rsp_chan never loses or repeats an item.
// Synchronous reset empties the queue and returns the scanner to plain text.
`default_nettype none

module url_span_marker_top #(
   parameter int SCHEME_MAX = usm_pkg::SCHEME_MAX_DEF
) (
   input  logic      clock,
   input  logic      reset,
   usm_req_if.sink   req_chan,
   usm_rsp_if.source rsp_chan
);
   import usm_pkg::*;

   localparam int LETTER_HOLD = (SCHEME_MAX > 3) ? SCHEME_MAX : 3;
   localparam int QUEUE_DEPTH = LETTER_HOLD + 5;
   localparam int CW          = $clog2(QUEUE_DEPTH + 1);

   // Queue entries: index 0 is the output head.
   logic [7:0] ent_byte_ff [QUEUE_DEPTH];
   logic       ent_link_ff [QUEUE_DEPTH];
   logic       ent_last_ff [QUEUE_DEPTH];
   logic [7:0] ent_byte_in [QUEUE_DEPTH];
   logic       ent_link_in [QUEUE_DEPTH];
   logic       ent_last_in [QUEUE_DEPTH];
   logic [7:0] ent_byte_mod [QUEUE_DEPTH];
   logic       ent_link_mod [QUEUE_DEPTH];
   logic       ent_last_mod [QUEUE_DEPTH];

   // Total entries and the decided entries at the front.
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [CW-1:0]    dec_ff, dec_in;
   logic [CW-1:0]    hold_cnt, rel_cnt, plain_cnt, link_lo, link_hi;
   logic [CNT_W-1:0] hold_wide;
   decision_type     decision;
   logic             take, pop;

   // Handshakes.
   assign req_chan.ready    = (cnt_ff < CW'(QUEUE_DEPTH));
   assign take              = req_chan.valid && req_chan.ready;
   assign rsp_chan.valid    = (dec_ff != '0);
   assign pop               = rsp_chan.valid && rsp_chan.ready;
   assign rsp_chan.out_byte = ent_byte_ff[0];
   assign rsp_chan.out_link = ent_link_ff[0];
   assign rsp_chan.out_last = ent_last_ff[0];

   // Undecided bytes sit behind the decided ones.
   assign hold_cnt  = cnt_ff - dec_ff;
   assign hold_wide = CNT_W'(hold_cnt);

   usm_scan #(
      .SCHEME_MAX (SCHEME_MAX)
   ) u_scan (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .scan_byte (req_chan.in_byte),
      .scan_last (req_chan.in_last),
      .hold_cnt  (hold_wide),
      .decision  (decision)
   );

   // Range of released held bytes that turn into link bytes.
   assign rel_cnt   = decision.rel_cnt[CW-1:0];
   assign plain_cnt = decision.plain_cnt[CW-1:0];
   assign link_lo   = dec_ff + plain_cnt;
   assign link_hi   = dec_ff + rel_cnt;

   // Mark link bytes and write the new item at the tail.
   always_comb begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         ent_byte_mod[i] = ent_byte_ff[i];
         ent_link_mod[i] = ent_link_ff[i];
         ent_last_mod[i] = ent_last_ff[i];
         if (take && (CW'(i) >= link_lo) && (CW'(i) < link_hi)) begin
            ent_link_mod[i] = 1'b1;
         end
         if (take && (CW'(i) == cnt_ff)) begin
            ent_byte_mod[i] = req_chan.in_byte;
            ent_link_mod[i] = decision.emit && decision.link;
            ent_last_mod[i] = req_chan.in_last;
         end
      end
   end

   // Shift toward the head when the output item is taken.
   always_comb begin
      for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
         ent_byte_in[i] = pop ? ent_byte_mod[i + 1] : ent_byte_mod[i];
         ent_link_in[i] = pop ? ent_link_mod[i + 1] : ent_link_mod[i];
         ent_last_in[i] = pop ? ent_last_mod[i + 1] : ent_last_mod[i];
      end
      ent_byte_in[QUEUE_DEPTH - 1] = ent_byte_mod[QUEUE_DEPTH - 1];
      ent_link_in[QUEUE_DEPTH - 1] = ent_link_mod[QUEUE_DEPTH - 1];
      ent_last_in[QUEUE_DEPTH - 1] = ent_last_mod[QUEUE_DEPTH - 1];
   end

   // Count updates.
   always_comb begin
      cnt_in = cnt_ff;
      dec_in = dec_ff;
      if (take) begin
         cnt_in = cnt_ff + CW'(1);
         dec_in = link_hi + CW'(decision.emit);
      end
      if (pop) begin
         cnt_in = cnt_in - CW'(1);
         dec_in = dec_in - CW'(1);
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         dec_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
         dec_ff <= dec_in;
      end
   end

   // Queue payload registers.
   always_ff @(posedge clock) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         ent_byte_ff[i] <= ent_byte_in[i];
         ent_link_ff[i] <= ent_link_in[i];
         ent_last_ff[i] <= ent_last_in[i];
      end
   end

endmodule

`default_nettype wire

>>> tb/sv/link_mark_check_pkg.sv
`timescale 1ns / 1ps
// Scoreboard class that predicts the link marks of every text byte and checks the results.
package link_mark_check_pkg;
   import usm_pkg::*;

   // Lookback limits of the scanner at the default scheme size.
   localparam int SCHEME_LIMIT = SCHEME_MAX_DEF;
   localparam int LETTER_KEEP  = (SCHEME_LIMIT > 3) ? SCHEME_LIMIT : 3;

   // One released byte as it should leave the block.
   typedef struct packed {
      logic [7:0] text;
      logic       link;
      logic       last;
   } mark_type;

   class link_mark_scoreboard;
      mark_type      pending_marks[$];
      mark_type      step_marks[$];
      logic [7:0]    held[$];
      int            letter_run;
      link_mode_type mode;
      prefix_type    prefix;
      int            errors;

      function new();
         errors = 0;
         clear_scan();
      endfunction

      function void clear_scan();
         held.delete();
         letter_run = 0;
         mode       = LINK_NONE;
         prefix     = PFX_NONE;
      endfunction

      function bit is_letter(logic [7:0] b);
         return (b >= CH_LOWER_A && b <= CH_LOWER_Z) || (b >= CH_UPPER_A && b <= CH_UPPER_Z);
      endfunction

      function bit is_w_char(logic [7:0] b);
         return b == CH_W_LOWER || b == CH_W_UPPER;
      endfunction

      // Scheme links accept a few punctuation marks that www links do not.
      function bit allowed_in_link(logic [7:0] b, link_mode_type m);
         if (is_letter(b) || (b >= CH_DIGIT_0 && b <= CH_DIGIT_9) ||
             b == CH_SLASH || b == CH_PERCENT || b == CH_DOT) begin
            return 1'b1;
         end
         if (m == LINK_SCHEME) begin
            return b == CH_DASH || b == CH_UNDERSCORE || b == CH_QUESTION || b == CH_EQUALS;
         end
         return 1'b0;
      endfunction

      function void mark(logic [7:0] b, logic linked);
         mark_type m;
         m.text = b;
         m.link = linked;
         m.last = 1'b0;
         step_marks.push_back(m);
      endfunction

      // Release the oldest held bytes with one link flag.
      function void release_front(int cnt, logic linked);
         if (cnt > held.size()) cnt = held.size();
         repeat (cnt) mark(held.pop_front(), linked);
      endfunction

      // Judge a byte outside any link with no colon pending.
      function void judge_plain(logic [7:0] b);
         int n;
         n = held.size();
         if (b == CH_COLON) begin
            held.push_back(b);
            prefix = PFX_COLON;
         end else if (b == CH_DOT && letter_run >= 3 && n >= 3 && is_w_char(held[n-1]) &&
                      is_w_char(held[n-2]) && is_w_char(held[n-3])) begin
            // Only the last three w and the dot belong to a www link.
            release_front(n - 3, 1'b0);
            release_front(3, 1'b1);
            mark(b, 1'b1);
            letter_run = 0;
            mode       = LINK_WWW;
         end else if (is_letter(b)) begin
            // Letters too far back can no longer be part of a scheme.
            if (letter_run >= LETTER_KEEP) begin
               release_front(1, 1'b0);
               letter_run--;
            end
            held.push_back(b);
            letter_run++;
         end else begin
            release_front(held.size(), 1'b0);
            letter_run = 0;
            mark(b, 1'b0);
         end
      endfunction

      // An unfinished separator turns plain and the byte is judged again.
      function void break_prefix(logic [7:0] b);
         release_front(held.size(), 1'b0);
         letter_run = 0;
         prefix     = PFX_NONE;
         judge_plain(b);
      endfunction

      // Work out the marks that one accepted text byte releases.
      function void note_byte(logic [7:0] b, logic last);
         int keep;
         step_marks.delete();
         if (mode != LINK_NONE) begin
            if (allowed_in_link(b, mode)) begin
               mark(b, 1'b1);
            end else begin
               mode = LINK_NONE;
               judge_plain(b);
            end
         end else if (prefix == PFX_COLON) begin
            if (b == CH_SLASH) begin
               held.push_back(b);
               prefix = PFX_SLASH;
            end else begin
               break_prefix(b);
            end
         end else if (prefix == PFX_SLASH) begin
            if (b == CH_SLASH) begin
               keep = (letter_run < SCHEME_LIMIT) ? letter_run : SCHEME_LIMIT;
               release_front(letter_run - keep, 1'b0);
               release_front(held.size(), 1'b1);
               mark(b, 1'b1);
               letter_run = 0;
               prefix     = PFX_NONE;
               mode       = LINK_SCHEME;
            end else begin
               break_prefix(b);
            end
         end else begin
            judge_plain(b);
         end

         // The final byte of a text flushes everything as plain.
         if (last) begin
            release_front(held.size(), 1'b0);
            if (step_marks.size() > 0) step_marks[step_marks.size()-1].last = 1'b1;
            clear_scan();
         end
         foreach (step_marks[i]) pending_marks.push_back(step_marks[i]);
      endfunction

      // Compare one released byte with the oldest expected mark.
      function void check_byte(logic [7:0] b, logic linked, logic last);
         mark_type want;
         if (pending_marks.size() == 0) begin
            $display("%0t: unexpected item: byte %h link %b last %b", $time, b, linked, last);
            errors++;
            return;
         end
         want = pending_marks.pop_front();
         if (want.text !== b) begin
            $display("%0t: out_byte expected %h actual %h", $time, want.text, b);
            errors++;
         end
         if (want.link !== linked) begin
            $display("%0t: out_link expected %b actual %b (byte %h)", $time, want.link, linked,
                     want.text);
            errors++;
         end
         if (want.last !== last) begin
            $display("%0t: out_last expected %b actual %b (byte %h)", $time, want.last, last,
                     want.text);
            errors++;
         end
      endfunction

      function int outstanding();
         return pending_marks.size();
      endfunction
   endclass

endpackage

>>> tb/sv/url_span_marker_top_tb.sv
`timescale 1ns / 1ps
// Top-level testbench of the URL span marker: text stimulus, stalls and result checking.
module url_span_marker_top_tb;
   import usm_pkg::*;
   import link_mark_check_pkg::*;

   localparam int RANDOM_ITEMS = 350;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 60;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   cycles = 0;
   int   sent = 0;
   bit   calm = 1'b0;
   logic [7:0] text[$];
   link_mark_scoreboard marks;

   usm_req_if req_chan();
   usm_rsp_if rsp_chan();

   url_span_marker_top u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always #5 clock = ~clock;

   // Hard stop if the run hangs.
   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // Mostly short gaps, some long ones, none at all in calm stretches.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 20);
   endfunction

   function automatic logic [7:0] pick_letter();
      logic [7:0] r;
      r = 8'($urandom_range(0, 25));
      return ($urandom_range(0, 1) ? CH_LOWER_A : CH_UPPER_A) + r;
   endfunction

   function automatic logic [7:0] pick_link_char(bit scheme);
      case ($urandom_range(0, scheme ? 7 : 4))
         0, 1: return pick_letter();
         2: return CH_DIGIT_0 + 8'($urandom_range(0, 9));
         3: return $urandom_range(0, 1) ? CH_SLASH : CH_PERCENT;
         4: return CH_DOT;
         5: return $urandom_range(0, 1) ? CH_DASH : CH_UNDERSCORE;
         default: return $urandom_range(0, 1) ? CH_QUESTION : CH_EQUALS;
      endcase
   endfunction

   function automatic void append_string(string s);
      for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
   endfunction

   // Send the text buffer as one text, the final byte flagged last.
   task automatic send_text();
      int gap;
      for (int i = 0; i < text.size(); i++) begin
         gap = pick_gap();
         if (gap > 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_chan.valid   <= 1'b1;
         req_chan.in_byte <= text[i];
         req_chan.in_last <= (i == text.size() - 1);
         do @(posedge clock); while (req_chan.ready !== 1'b1);
         marks.note_byte(text[i], i == text.size() - 1);
         sent++;
      end
   endtask

   // Receiver stalls.
   initial begin
      int stall;
      stall = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            stall--;
         end else begin
            rsp_chan.ready <= 1'b1;
            stall = pick_gap();
         end
      end
   end

   // Every item taken by the receiver is checked.
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         marks.check_byte(rsp_chan.out_byte, rsp_chan.out_link, rsp_chan.out_last);
      end
   end

   initial begin
      int start;
      int target;
      marks = new();
      req_chan.valid   <= 1'b0;
      req_chan.in_byte <= 8'h00;
      req_chan.in_last <= 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Scheme link with every extra character, ended by high and zero bytes.
      text.delete();
      append_string("ab://c-_?=%");
      text.push_back(8'hFF);
      text.push_back(8'h00);
      send_text();
      // Broken colon, broken ":/", then four w before the dot and a www link end.
      text.delete();
      append_string(":b:/wWwW.z-");
      send_text();
      // Separator with no scheme letters, ending the text.
      text.delete();
      append_string("://");
      send_text();

      // Random texts built mostly from well-formed link pieces.
      start = sent;
      while (sent - start < RANDOM_ITEMS) begin
         if ($urandom_range(0, 3) == 0) calm = !calm;
         target = $urandom_range(1, 30);
         text.delete();
         while (text.size() < target) begin
            case ($urandom_range(0, 9))
               0, 1, 2: begin
                  // Scheme link, now and then with a scheme longer than the lookback.
                  repeat (($urandom_range(0, 9) == 0) ? $urandom_range(30, 40) :
                          $urandom_range(0, 5)) text.push_back(pick_letter());
                  text.push_back(CH_COLON);
                  text.push_back(CH_SLASH);
                  text.push_back(CH_SLASH);
                  repeat ($urandom_range(0, 8)) text.push_back(pick_link_char(1'b1));
               end
               3, 4: begin
                  repeat ($urandom_range(3, 4))
                     text.push_back($urandom_range(0, 1) ? CH_W_LOWER : CH_W_UPPER);
                  text.push_back(CH_DOT);
                  repeat ($urandom_range(0, 6)) text.push_back(pick_link_char(1'b0));
               end
               5: begin
                  // Separator cut short by an arbitrary byte.
                  repeat ($urandom_range(0, 3)) text.push_back(pick_letter());
                  text.push_back(CH_COLON);
                  if ($urandom_range(0, 1)) text.push_back(CH_SLASH);
                  text.push_back(8'($urandom_range(0, 255)));
               end
               6: begin
                  repeat ($urandom_range(1, 10)) text.push_back(pick_letter());
               end
               default: begin
                  repeat ($urandom_range(1, 4)) text.push_back(8'($urandom_range(0, 255)));
               end
            endcase
         end
         send_text();
      end
      req_chan.valid <= 1'b0;

      // Drain the remaining results, then watch for strays.
      while (marks.outstanding() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (marks.errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
